// ----- hw/rtl/hav_pkg.sv -----
// ----------------------------------------------------------------------------
// hav_pkg
// Shared constants, payload types and the CORDIC angle table.
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int unsigned LatW  = 30;
  localparam int unsigned LonW  = 31;
  localparam int unsigned DistW = 34;
  localparam int unsigned RadW  = 24;
  localparam int unsigned DegW  = 33;   // reduced angle in Q23, signed
  localparam int unsigned CW    = 34;   // CORDIC datapath width, signed Q30

  localparam logic signed [DegW-1:0] TurnQ23    = 33'sd3019898880;
  localparam logic signed [DegW-1:0] HalfTurnQ23 = 33'sd1509949440;
  localparam logic signed [DegW-1:0] QuarterQ23 = 33'sd754974720;
  localparam logic [31:0]            Deg2Rad    = 32'd2398762259;
  localparam logic signed [CW-1:0]   CordicStart = 34'sd652032874;
  localparam logic signed [CW-1:0]   OneQ30     = 34'sd1073741824;
  localparam logic signed [CW-1:0]   HalfPiQ30  = 34'sd1686629713;

  typedef struct packed {
    logic [LatW-1:0]  start_lat;
    logic [LonW-1:0]  start_lon;
    logic [LatW-1:0]  end_lat;
    logic [LonW-1:0]  end_lon;
  } hav_in_t;

  typedef struct packed {
    logic [DistW-1:0] distance;
  } hav_out_t;

  function automatic logic signed [CW-1:0] atan_lut(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0: v = 32'h3243F6A8;  5'd1: v = 32'h1DAC6705;
      5'd2: v = 32'h0FADBAFC;  5'd3: v = 32'h07F56EA6;
      5'd4: v = 32'h03FEAB76;  5'd5: v = 32'h01FFD55B;
      5'd6: v = 32'h00FFFAAA;  5'd7: v = 32'h007FFF55;
      5'd8: v = 32'h003FFFEA;  5'd9: v = 32'h001FFFFD;
      5'd30: v = 32'h00000001; 5'd31: v = 32'h00000000;
      default: v = 32'h00100000 >> (k - 5'd10);
    endcase
    return CW'(signed'({1'b0, v}));
  endfunction

endpackage

// ----- hw/rtl/hav_stream_if.sv -----
// ----------------------------------------------------------------------------
// hav_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface hav_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/hav_cordic_rot.sv -----
// ----------------------------------------------------------------------------
// hav_cordic_rot
// Pipelined CORDIC, one stage per iteration. Rotation mode drives z to zero;
// vectoring mode drives y to zero. Side payload travels alongside.
// ----------------------------------------------------------------------------
module hav_cordic_rot
  import hav_pkg::*;
#(
  parameter int unsigned Iter     = 24,
  parameter bit          Vector   = 1'b0,
  parameter int unsigned SideW    = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [CW-1:0] x_i,
  input  logic signed [CW-1:0] y_i,
  input  logic signed [CW-1:0] z_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic signed [CW-1:0] x_o,
  output logic signed [CW-1:0] y_o,
  output logic signed [CW-1:0] z_o,
  output logic [SideW-1:0]     side_o
);
  logic signed [CW-1:0] x_q [Iter+1];
  logic signed [CW-1:0] y_q [Iter+1];
  logic signed [CW-1:0] z_q [Iter+1];
  logic [SideW-1:0]     s_q [Iter+1];
  logic                 v_q [Iter+1];

  assign x_q[0] = x_i;
  assign y_q[0] = y_i;
  assign z_q[0] = z_i;
  assign s_q[0] = side_i;
  assign v_q[0] = valid_i;

  for (genvar i = 0; i < Iter; i++) begin : g_stage
    localparam logic [4:0] K = 5'(i % 32);
    logic signed [CW-1:0] xs, ys, x_d, y_d, z_d;
    logic                 pos;
    assign xs  = x_q[i] >>> K;
    assign ys  = y_q[i] >>> K;
    assign pos = Vector ? (y_q[i] > 0) : (z_q[i] >= 0);
    always_comb begin
      if (pos ^ Vector) begin
        x_d = x_q[i] - ys; y_d = y_q[i] + xs; z_d = z_q[i] - atan_lut(K);
      end else begin
        x_d = x_q[i] + ys; y_d = y_q[i] - xs; z_d = z_q[i] + atan_lut(K);
      end
      if (Vector && pos) begin
        x_d = x_q[i] + ys; y_d = y_q[i] - xs; z_d = z_q[i] + atan_lut(K);
      end
    end
    logic signed [CW-1:0] xr_q, yr_q, zr_q;
    logic [SideW-1:0]     sr_q;
    logic                 vr_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vr_q <= 1'b0;
      end else if (en_i) begin
        vr_q <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        xr_q <= x_d; yr_q <= y_d; zr_q <= z_d; sr_q <= s_q[i];
      end
    end
    assign x_q[i+1] = xr_q;
    assign y_q[i+1] = yr_q;
    assign z_q[i+1] = zr_q;
    assign s_q[i+1] = sr_q;
    assign v_q[i+1] = vr_q;
  end

  assign x_o     = x_q[Iter];
  assign y_o     = y_q[Iter];
  assign z_o     = z_q[Iter];
  assign side_o  = s_q[Iter];
  assign valid_o = v_q[Iter];
endmodule

// ----- hw/rtl/hav_isqrt.sv -----
// ----------------------------------------------------------------------------
// hav_isqrt
// Pipelined restoring floor square root of a 62-bit value, one result bit
// per stage. Yields 31-bit root.
// ----------------------------------------------------------------------------
module hav_isqrt
  import hav_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [61:0]      v_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [30:0]      root_o,
  output logic [SideW-1:0] side_o
);
  localparam int unsigned N = 31;
  logic [61:0]      r_q  [N+1];
  logic [30:0]      q_q  [N+1];
  logic [61:0]      v_q  [N+1];
  logic [SideW-1:0] s_q  [N+1];
  logic             vl_q [N+1];

  assign r_q[0]  = '0;
  assign q_q[0]  = '0;
  assign v_q[0]  = v_i;
  assign s_q[0]  = side_i;
  assign vl_q[0] = valid_i;

  for (genvar i = 0; i < N; i++) begin : g_bit
    // remainder gains next two bits; trial 4q+1
    logic [63:0] rem, trial;
    logic [61:0] r_d;
    logic [30:0] q_d;
    assign rem   = {r_q[i], v_q[i][61:60]};
    assign trial = {31'd0, q_q[i], 2'b01};
    always_comb begin
      if (rem >= trial) begin
        r_d = 62'(rem - trial);
        q_d = {q_q[i][29:0], 1'b1};
      end else begin
        r_d = 62'(rem);
        q_d = {q_q[i][29:0], 1'b0};
      end
    end
    logic [61:0]      rr_q, vr_q;
    logic [30:0]      qr_q;
    logic [SideW-1:0] sr_q;
    logic             vlr_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vlr_q <= 1'b0;
      end else if (en_i) begin
        vlr_q <= vl_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rr_q <= r_d; qr_q <= q_d; vr_q <= {v_q[i][59:0], 2'b00}; sr_q <= s_q[i];
      end
    end
    assign r_q[i+1]  = rr_q;
    assign q_q[i+1]  = qr_q;
    assign v_q[i+1]  = vr_q;
    assign s_q[i+1]  = sr_q;
    assign vl_q[i+1] = vlr_q;
  end

  assign root_o  = q_q[N];
  assign side_o  = s_q[N];
  assign valid_o = vl_q[N];
endmodule

// ----- hw/rtl/hav_prep.sv -----
// ----------------------------------------------------------------------------
// hav_prep
// Two-stage angle front end: reduce a Q23 degree angle to +-90, then scale to
// Q30 radians. Flip flag marks a reflected cosine.
// ----------------------------------------------------------------------------
module hav_prep
  import hav_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [DegW-1:0] deg_i,
  output logic signed [CW-1:0]   rad_o,
  output logic                   flip_o
);
  logic signed [DegW:0]   r0, r1;
  logic signed [DegW-1:0] red_d, red_q;
  logic                   flip_d, flip_q, flip2_q;

  always_comb begin
    // inputs lie within +-256 degrees; one step brings them into [-180,180)
    r0 = (DegW+1)'(deg_i);
    if (r0 >= (DegW+1)'(HalfTurnQ23)) r0 = r0 - (DegW+1)'(TurnQ23);
    if (r0 < -(DegW+1)'(HalfTurnQ23)) r0 = r0 + (DegW+1)'(TurnQ23);
    flip_d = 1'b0;
    r1 = r0;
    if (r0 > (DegW+1)'(QuarterQ23)) begin
      r1 = (DegW+1)'(HalfTurnQ23) - r0; flip_d = 1'b1;
    end else if (r0 < -(DegW+1)'(QuarterQ23)) begin
      r1 = -(DegW+1)'(HalfTurnQ23) - r0; flip_d = 1'b1;
    end
    red_d = DegW'(r1);
  end

  logic [31:0] mag;
  logic [63:0] prod_d;
  logic [31:0] prod_q;
  logic        neg_q;
  assign mag    = red_q[DegW-1] ? 32'(-red_q) : 32'(red_q);
  assign prod_d = 64'(mag) * 64'(Deg2Rad);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= red_d;
      flip_q  <= flip_d;
      prod_q  <= prod_d[61:30];
      neg_q   <= red_q[DegW-1];
      flip2_q <= flip_q;
    end
  end

  assign rad_o  = neg_q ? -CW'(signed'({1'b0, prod_q})) : CW'(signed'({1'b0, prod_q}));
  assign flip_o = flip2_q;
endmodule

// ----- hw/rtl/haversine_distance.sv -----
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two points, fully pipelined.
// ----------------------------------------------------------------------------
// Usage: in_if carries one point pair (lat/lon, signed degrees * 2^22) per
// transfer; out_if returns distance in radius units * 2^8, truncated.
// earth_radius_we_i/earth_radius_i load the radius; write only while idle.
// Throughput: one pair per cycle while the output is not stalled. Path: angle
// prep, sin/cos CORDIC, products, square roots, atan2 CORDIC, then clamp and
// radius multiply into the output register.
// ANGLE_ITERATIONS defaults to 24. The long chain is set by the two CORDIC
// pipelines and the bit-per-stage square root.
// The whole pipeline advances when the output register is empty or being
// taken; a stall freezes every stage, so nothing is lost or repeated.
// Reset clears all valid bits and loads the radius with 6371000.
// ----------------------------------------------------------------------------
module haversine_distance
  import hav_pkg::*;
#(
  parameter int unsigned ANGLE_ITERATIONS = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            earth_radius_we_i,
  input  logic [RadW-1:0] earth_radius_i,
  hav_stream_if.sink      in_if,
  hav_stream_if.source    out_if
);
  logic            en;
  logic [RadW-1:0] radius_q;
  logic            ov_q;
  logic [DistW-1:0] od_q;

  assign en          = !ov_q || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RadW'(6371000);
    end else if (earth_radius_we_i) begin
      radius_q <= earth_radius_i;
    end
  end

  // Angle front end: four reductions
  hav_in_t d;
  assign d = in_if.data;
  logic signed [DegW-1:0] deg [4];
  assign deg[0] = DegW'(signed'(d.end_lat))   - DegW'(signed'(d.start_lat));
  assign deg[1] = DegW'(signed'(d.end_lon))   - DegW'(signed'(d.start_lon));
  assign deg[2] = DegW'(signed'({d.start_lat, 1'b0}));
  assign deg[3] = DegW'(signed'({d.end_lat, 1'b0}));

  logic                 v_p1_q, v_p2_q;
  logic signed [CW-1:0] rad [4];
  logic                 flip [4];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_p1_q <= 1'b0; v_p2_q <= 1'b0;
    end else if (en) begin
      v_p1_q <= in_if.valid; v_p2_q <= v_p1_q;
    end
  end

  logic                 v_sc [4];
  logic signed [CW-1:0] sx [4], sy [4], sz [4];
  logic                 sf [4];
  for (genvar j = 0; j < 4; j++) begin : g_sc
    hav_prep u_prep (
      .clk_i, .en_i(en), .deg_i(deg[j]), .rad_o(rad[j]), .flip_o(flip[j])
    );
    hav_cordic_rot #(.Iter(ANGLE_ITERATIONS), .Vector(1'b0), .SideW(1)) u_rot (
      .clk_i, .rst_ni, .en_i(en), .valid_i(v_p2_q),
      .x_i(CordicStart), .y_i('0), .z_i(rad[j]), .side_i(flip[j]),
      .valid_o(v_sc[j]), .x_o(sx[j]), .y_o(sy[j]), .z_o(sz[j]), .side_o(sf[j])
    );
  end

  // Haversine term: three product stages
  logic signed [CW-1:0] c1, c2;
  assign c1 = sf[2] ? -sx[2] : sx[2];
  assign c2 = sf[3] ? -sx[3] : sx[3];
  logic signed [67:0]   m1, m2, m3;
  logic signed [CW-1:0] s1sq_q, s2sq_q, cc_q, s1sq2_q, prod_q;
  logic signed [CW:0]   a_sum;
  logic [CW-1:0]        a_q;
  logic                 v_m1_q, v_m2_q, v_m3_q;
  assign m1 = 68'(sy[0]) * 68'(sy[0]);
  assign m2 = 68'(sy[1]) * 68'(sy[1]);
  assign m3 = 68'(c1) * 68'(c2);
  logic signed [67:0] m4;
  assign m4 = 68'(cc_q) * 68'(s2sq_q);
  assign a_sum = (CW+1)'(s1sq2_q) + (CW+1)'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_m1_q <= 1'b0; v_m2_q <= 1'b0; v_m3_q <= 1'b0;
    end else if (en) begin
      v_m1_q <= v_sc[0]; v_m2_q <= v_m1_q; v_m3_q <= v_m2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1sq_q  <= CW'(m1 >>> 30);
      s2sq_q  <= CW'(m2 >>> 30);
      cc_q    <= CW'(m3 >>> 30);
      s1sq2_q <= s1sq_q;
      prod_q  <= CW'(m4 >>> 30);
      if (a_sum < 0)                      a_q <= '0;
      else if (a_sum > (CW+1)'(OneQ30))   a_q <= CW'(OneQ30);
      else                                a_q <= CW'(a_sum);
    end
  end

  // Two square roots in parallel
  logic [61:0] va, vb;
  logic [30:0] rp, rq;
  logic        v_sq, v_unused;
  logic [0:0]  s_unused0, s_unused1;
  assign va = {a_q[31:0], 30'd0};
  assign vb = {32'(CW'(OneQ30) - a_q), 30'd0};
  hav_isqrt #(.SideW(1)) u_sqp (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_m3_q), .v_i(va), .side_i(1'b0),
    .valid_o(v_sq), .root_o(rp), .side_o(s_unused0)
  );
  hav_isqrt #(.SideW(1)) u_sqq (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_m3_q), .v_i(vb), .side_i(1'b0),
    .valid_o(v_unused), .root_o(rq), .side_o(s_unused1)
  );

  // atan2 in vectoring mode
  logic                 v_at;
  logic signed [CW-1:0] ax, ay, az;
  logic [0:0]           s_unused2;
  hav_cordic_rot #(.Iter(ANGLE_ITERATIONS), .Vector(1'b1), .SideW(1)) u_atan (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v_sq),
    .x_i(CW'({1'b0, rq})), .y_i(CW'({1'b0, rp})), .z_i('0), .side_i(1'b0),
    .valid_o(v_at), .x_o(ax), .y_o(ay), .z_o(az), .side_o(s_unused2)
  );

  // Clamp, then radius multiply
  logic [30:0] ang_q;
  logic        v_c_q;
  logic [56:0] dist_full;
  assign dist_full = 57'({ang_q, 1'b0}) * 57'(radius_q);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_c_q <= 1'b0; ov_q <= 1'b0;
    end else if (en) begin
      v_c_q <= v_at; ov_q <= v_c_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (az < 0)               ang_q <= '0;
      else if (az > HalfPiQ30)  ang_q <= 31'(HalfPiQ30);
      else                      ang_q <= 31'(az);
      od_q <= DistW'(dist_full >> 22);
    end
  end

  assign out_if.valid         = ov_q;
  assign out_if.data.distance = od_q;
endmodule
